// ===== rtl/efue_pkg.sv =====
package efue_pkg;

    localparam int unsigned COUNTS_PER_TURN_DEF = 8192;

    localparam int ANGLE_IN_W  = 13;
    localparam int SPEED_W     = 16;
    localparam int CURRENT_W   = 16;
    localparam int STAMP_W     = 16;
    localparam int ANGLE_OUT_W = 16;
    localparam int SUM_W       = 64;

    localparam int SPEED_LSB   = ANGLE_IN_W;
    localparam int CURRENT_LSB = SPEED_LSB + SPEED_W;
    localparam int STAMP_LSB   = CURRENT_LSB + CURRENT_W;
    localparam int S_FIELDS_W  = STAMP_LSB + STAMP_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    localparam int M_SPEED_LSB   = ANGLE_OUT_W;
    localparam int M_CURRENT_LSB = M_SPEED_LSB + SPEED_W;
    localparam int M_STAMP_LSB   = M_CURRENT_LSB + CURRENT_W;
    localparam int M_SUM_LSB     = M_STAMP_LSB + STAMP_W;
    localparam int M_TDATA_W     = M_SUM_LSB + SUM_W;

    localparam int unsigned SPEED_DIV = 60;
    localparam int unsigned TIME_DIV  = 1000000;
    localparam int REM_W = $clog2(TIME_DIV);

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

// ===== rtl/encoder_feedback_unwrap_estimate.sv =====
// Channel   Direction  Transfer contents
// s_axis    in         tuser: mode; tdata: angle_in, speed_in, current_in, stamp_in
// m_axis    out        tdata: angle_out, speed_out, current_out, stamp_out, angle_sum
// cfg       in         i_cfg_wr_en / i_cfg_wr_data: reverse_direction
//
// A feedback frame updates the state in its accept cycle and then waits in S_EMIT to be
// offered, so s_axis_tready stays low until S_EMIT hands the result to the output register.
// A query runs a bit-serial divide by 60, a 16-step shift-add multiply by the elapsed time
// and a bit-serial divide by 1000000 through one shared shift register, then S_FIX forms
// the angle. A stalled output holds the result and the block.
// Reset is synchronous and clears the stored frame, the turn sum and the direction.
module encoder_feedback_unwrap_estimate
    import efue_pkg::*;
#(
    parameter int unsigned COUNTS_PER_TURN = COUNTS_PER_TURN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 s_axis_tuser,   // mode
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // angle_in, speed_in, current_in, stamp_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // angle_out, speed_out, current_out,
                                                 // stamp_out, angle_sum
);

    localparam int CW    = $clog2(COUNTS_PER_TURN + 1);
    localparam int N1W   = SPEED_W + 1 + CW;
    localparam int PW    = N1W + STAMP_W;
    localparam int CNT_W = $clog2(PW + 1);
    localparam int DW    = 18;

    localparam logic signed [DW-1:0] CPT_S  = DW'(COUNTS_PER_TURN);
    localparam logic signed [DW-1:0] HALF_S = DW'(COUNTS_PER_TURN / 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_MUL,
        S_DIV2,
        S_FIX,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [PW-1:0]           r_num, n_num;
    logic [N1W-1:0]          r_quo, n_quo;
    logic [STAMP_W-1:0]      r_dt, n_dt;
    logic                    r_neg, n_neg;
    logic [ANGLE_OUT_W-1:0]  r_res_angle, n_res_angle;
    logic [STAMP_W-1:0]      r_res_stamp, n_res_stamp;
    logic                    r_rev, n_rev;
    logic [ANGLE_OUT_W-1:0]  r_last_angle, n_last_angle;
    logic [SPEED_W-1:0]      r_last_speed, n_last_speed;
    logic [CURRENT_W-1:0]    r_last_current, n_last_current;
    logic [STAMP_W-1:0]      r_last_stamp, n_last_stamp;
    logic [SUM_W-1:0]        r_turn_sum, n_turn_sum;
    logic                    r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]    r_out_data, n_out_data;

    logic [ANGLE_IN_W-1:0]   w_angle_in;
    logic [SPEED_W-1:0]      w_speed_in;
    logic [CURRENT_W-1:0]    w_current_in;
    logic [STAMP_W-1:0]      w_stamp_in;
    logic signed [DW-1:0]    w_ang_raw, w_ang, w_prev, w_d, w_dw;
    logic [SUM_W-1:0]        w_sum_n;
    logic [SPEED_W:0]        w_spd_ext, w_mag;
    logic [N1W-1:0]          w_n1;
    logic [REM_W:0]          w_rem2, w_divisor;
    logic                    w_ge;
    logic [REM_W-1:0]        w_rem_n;
    logic [PW-1:0]           w_acc;
    logic [ANGLE_OUT_W-1:0]  w_e, w_est;
    logic                    w_out_free;

    assign w_angle_in   = s_axis_tdata[ANGLE_IN_W-1:0];
    assign w_speed_in   = s_axis_tdata[SPEED_LSB +: SPEED_W];
    assign w_current_in = s_axis_tdata[CURRENT_LSB +: CURRENT_W];
    assign w_stamp_in   = s_axis_tdata[STAMP_LSB +: STAMP_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        w_ang_raw = {{(DW - ANGLE_IN_W){1'b0}}, w_angle_in};
        w_ang     = r_rev ? (CPT_S - w_ang_raw) : w_ang_raw;
        w_prev    = {{(DW - ANGLE_OUT_W){r_last_angle[ANGLE_OUT_W-1]}}, r_last_angle};
        w_d       = w_ang - w_prev;
        if (w_d > HALF_S) begin
            w_dw = w_d - CPT_S;
        end else if (w_d < -HALF_S) begin
            w_dw = w_d + CPT_S;
        end else begin
            w_dw = w_d;
        end
        w_sum_n = r_turn_sum + {{(SUM_W - DW){w_dw[DW-1]}}, w_dw};

        w_spd_ext = {r_last_speed[SPEED_W-1], r_last_speed};
        w_mag     = r_last_speed[SPEED_W-1] ? (SPEED_W + 1)'(0 - w_spd_ext) : w_spd_ext;
        w_n1      = N1W'(w_mag) * N1W'(COUNTS_PER_TURN);

        w_rem2    = {r_rem, r_num[PW-1]};
        w_divisor = (r_state == S_DIV1) ? (REM_W + 1)'(SPEED_DIV) : (REM_W + 1)'(TIME_DIV);
        w_ge      = (w_rem2 >= w_divisor);
        w_rem_n   = w_ge ? REM_W'(w_rem2 - w_divisor) : REM_W'(w_rem2);

        w_acc = {r_num[PW-2:0], 1'b0} + (r_dt[STAMP_W-1] ? PW'(r_quo) : PW'(0));

        w_e   = r_neg ? ANGLE_OUT_W'(0 - r_quo[ANGLE_OUT_W-1:0]) : r_quo[ANGLE_OUT_W-1:0];
        w_est = r_last_angle + w_e;
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_rem          = r_rem;
        n_num          = r_num;
        n_quo          = r_quo;
        n_dt           = r_dt;
        n_neg          = r_neg;
        n_res_angle    = r_res_angle;
        n_res_stamp    = r_res_stamp;
        n_rev          = r_rev;
        n_last_angle   = r_last_angle;
        n_last_speed   = r_last_speed;
        n_last_current = r_last_current;
        n_last_stamp   = r_last_stamp;
        n_turn_sum     = r_turn_sum;
        n_out_valid    = r_out_valid;
        n_out_data     = r_out_data;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_wr_en) begin
            n_rev = i_cfg_wr_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == MODE_FRAME) begin
                        n_last_angle   = ANGLE_OUT_W'(w_ang);
                        n_last_speed   = r_rev ? SPEED_W'(0 - w_speed_in) : w_speed_in;
                        n_last_current = r_rev ? CURRENT_W'(0 - w_current_in) : w_current_in;
                        n_last_stamp   = w_stamp_in;
                        n_turn_sum     = w_sum_n;
                        n_res_angle    = ANGLE_OUT_W'(w_ang);
                        n_res_stamp    = w_stamp_in;
                        n_state        = S_EMIT;
                    end else begin
                        n_dt        = w_stamp_in - r_last_stamp;
                        n_neg       = r_last_speed[SPEED_W-1];
                        n_num       = {w_n1, {STAMP_W{1'b0}}};
                        n_rem       = '0;
                        n_cnt       = CNT_W'(N1W);
                        n_res_stamp = w_stamp_in;
                        n_state     = S_DIV1;
                    end
                end
            end
            S_DIV1: begin
                n_num = {r_num[PW-2:0], 1'b0};
                n_quo = {r_quo[N1W-2:0], w_ge};
                n_rem = w_rem_n;
                n_cnt = CNT_W'(r_cnt - 1'b1);
                if (r_cnt == CNT_W'(1)) begin
                    n_rem   = '0;
                    n_num   = '0;
                    n_cnt   = CNT_W'(STAMP_W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_num = w_acc;
                n_dt  = {r_dt[STAMP_W-2:0], 1'b0};
                n_cnt = CNT_W'(r_cnt - 1'b1);
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(PW);
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_num = {r_num[PW-2:0], 1'b0};
                n_quo = {r_quo[N1W-2:0], w_ge};
                n_rem = w_rem_n;
                n_cnt = CNT_W'(r_cnt - 1'b1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_res_angle = w_est;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_data  = {r_turn_sum, r_res_stamp, r_last_current, r_last_speed,
                                   r_res_angle};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_rev          <= 1'b0;
            r_last_angle   <= '0;
            r_last_speed   <= '0;
            r_last_current <= '0;
            r_last_stamp   <= '0;
            r_turn_sum     <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_rev          <= n_rev;
            r_last_angle   <= n_last_angle;
            r_last_speed   <= n_last_speed;
            r_last_current <= n_last_current;
            r_last_stamp   <= n_last_stamp;
            r_turn_sum     <= n_turn_sum;
            r_cnt          <= n_cnt;
            r_rem          <= n_rem;
            r_num          <= n_num;
            r_quo          <= n_quo;
            r_dt           <= n_dt;
            r_neg          <= n_neg;
            r_res_angle    <= n_res_angle;
            r_res_stamp    <= n_res_stamp;
            r_out_data     <= n_out_data;
        end
    end

endmodule

// ===== rtl/efue_checker.sv =====
module efue_checker
    import efue_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed or was dropped.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result offered right after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken again while the previous item is in progress.");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result appeared while the block was idle.");

endmodule

bind encoder_feedback_unwrap_estimate efue_checker u_efue_checker (.*);

// ===== verif/encoder_feedback_unwrap_estimate_test.sv =====
module encoder_feedback_unwrap_estimate_test;
    import efue_pkg::*;

    typedef struct packed {
        logic [ANGLE_OUT_W-1:0] angle;
        logic [SPEED_W-1:0]     speed;
        logic [CURRENT_W-1:0]   current;
        logic [STAMP_W-1:0]     stamp;
        logic [SUM_W-1:0]       sum;
    } t_feedback_result;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC,
        READY_LONG_STALL
    } t_ready_style;

    localparam bit DIR_FORWARD = 1'b0;
    localparam bit DIR_REVERSE = 1'b1;

    localparam int     TURN         = int'(COUNTS_PER_TURN_DEF);
    localparam int     HALF_TURN    = TURN / 2;
    localparam longint RPM_DIVISOR  = longint'(SPEED_DIV);
    localparam longint USEC_DIVISOR = longint'(TIME_DIV);
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES = 100;
    localparam int     PRINT_LIMIT  = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic                 i_cfg_wr_data = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic                 s_axis_tuser = 1'b0;        // mode
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;          // angle_in, speed_in, current_in, stamp_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;               // angle_out, speed_out, current_out,
                                                      // stamp_out, angle_sum

    bit                     reverse_mode = DIR_FORWARD;
    logic [ANGLE_OUT_W-1:0] held_angle = '0;
    logic [SPEED_W-1:0]     held_speed = '0;
    logic [CURRENT_W-1:0]   held_current = '0;
    logic [STAMP_W-1:0]     held_stamp = '0;
    logic [SUM_W-1:0]       unwrapped_sum = '0;

    t_feedback_result pending_results[$];

    int  error_count = 0;
    int  frames_sent = 0;
    int  queries_sent = 0;
    int  results_seen = 0;
    int  direction_writes = 0;
    int  burst_left = 1;
    bit  stream_held = 1'b0;
    int  idle_cycles = 0;

    t_ready_style ready_style = READY_ALWAYS;
    int           ready_count = 0;
    int           stall_left = 0;

    logic [ANGLE_IN_W-1:0] raw_angle = '0;
    logic [STAMP_W-1:0]    stamp_now = '0;

    encoder_feedback_unwrap_estimate uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_feedback_result apply_item(bit mode, logic [ANGLE_IN_W-1:0] angle,
                                                    logic [SPEED_W-1:0] speed,
                                                    logic [CURRENT_W-1:0] current,
                                                    logic [STAMP_W-1:0] stamp);
        t_feedback_result res;
        int pos;
        int prev;
        int step;
        logic [STAMP_W-1:0] elapsed;
        longint rate;
        longint drift;
        if (mode == MODE_FRAME) begin
            pos = int'(angle);
            if (reverse_mode == DIR_REVERSE) begin
                pos = TURN - pos;
                speed = 16'(0) - speed;
                current = 16'(0) - current;
            end
            prev = int'($signed(held_angle));
            step = pos - prev;
            if (step > HALF_TURN) begin
                step = step - TURN;
            end else if (step < -HALF_TURN) begin
                step = step + TURN;
            end
            unwrapped_sum = unwrapped_sum + longint'(step);
            held_angle = pos[15:0];
            held_speed = speed;
            held_current = current;
            held_stamp = stamp;
            res.angle = held_angle;
            res.stamp = held_stamp;
        end else begin
            elapsed = stamp - held_stamp;
            rate = longint'($signed(held_speed)) * TURN / RPM_DIVISOR;
            drift = rate * longint'(elapsed) / USEC_DIVISOR;
            res.angle = held_angle + drift[15:0];
            res.stamp = stamp;
        end
        res.speed = held_speed;
        res.current = held_current;
        res.sum = unwrapped_sum;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT) begin
            $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
        end
    endtask

    // The sender keeps tvalid high across a burst; a pause lowers it first.
    task automatic send_item(bit mode, logic [ANGLE_IN_W-1:0] angle, logic [SPEED_W-1:0] speed,
                             logic [CURRENT_W-1:0] current, logic [STAMP_W-1:0] stamp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= S_TDATA_W'({stamp, current, speed, angle});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_item(mode, angle, speed, current, stamp));
        if (mode == MODE_FRAME) begin
            frames_sent++;
        end else begin
            queries_sent++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            stream_held = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            stream_held = 1'b1;
        end
    endtask

    task automatic wait_results_drained();
        if (stream_held) begin
            s_axis_tvalid <= 1'b0;
            stream_held = 1'b0;
            @(posedge i_clk);
        end
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_direction(bit dir);
        wait_results_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= dir;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        reverse_mode = dir;
        direction_writes++;
    endtask

    task automatic test_directed_forward();
        send_item(MODE_QUERY, 13'h1FFF, 16'h8000, 16'h7FFF, 16'd1234);
        send_item(MODE_FRAME, 13'd4096, 16'd100, 16'd200, 16'd0);
        send_item(MODE_FRAME, 13'd0, 16'h7FFF, 16'h8000, 16'd10);
        send_item(MODE_FRAME, 13'h1FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_item(MODE_FRAME, 13'd4095, 16'd0, 16'd0, 16'd100);
        send_item(MODE_FRAME, 13'd1, 16'd5, 16'hFFFF, 16'd120);
        send_item(MODE_FRAME, 13'd4098, 16'd3000, 16'd7, 16'd100);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'd100);
        send_item(MODE_FRAME, 13'd1000, 16'h7FFF, 16'd1, 16'hFFFF);
        send_item(MODE_QUERY, 13'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'd0);
        send_item(MODE_FRAME, 13'd2000, 16'h8000, 16'h8000, 16'd500);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'd400);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'd30500);
    endtask

    task automatic test_directed_reverse();
        set_direction(DIR_REVERSE);
        send_item(MODE_FRAME, 13'd0, 16'h8000, 16'h8000, 16'd0);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'hFFFF);
        send_item(MODE_FRAME, 13'h1FFF, 16'h7FFF, 16'h7FFF, 16'd1000);
        send_item(MODE_FRAME, 13'd4096, 16'd1, 16'hFFFF, 16'd2000);
        send_item(MODE_FRAME, 13'd1, 16'hFF00, 16'd300, 16'd2500);
        send_item(MODE_QUERY, 13'd0, 16'd0, 16'd0, 16'd40000);
        send_item(MODE_FRAME, 13'd0, 16'd0, 16'd0, 16'd2600);
        send_item(MODE_QUERY, 13'h1FFF, 16'h7FFF, 16'h8000, 16'd2600);
    endtask

    task automatic random_items(int count);
        int pick;
        int step;
        logic [SPEED_W-1:0] speed;
        logic [CURRENT_W-1:0] current;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                step = $urandom_range(0, 9);
                if (step < 7) begin
                    raw_angle = raw_angle + 13'($urandom_range(0, 600) - 300);
                end else if (step < 9) begin
                    raw_angle = raw_angle + 13'(HALF_TURN + $urandom_range(0, 8) - 4);
                end else begin
                    raw_angle = 13'($urandom);
                end
                if ($urandom_range(0, 4) == 0) begin
                    speed = 16'($urandom);
                end else begin
                    speed = 16'($urandom_range(0, 6000)) - 16'd3000;
                end
                current = 16'($urandom);
                stamp_now = stamp_now + 16'($urandom_range(0, 3000));
                send_item(MODE_FRAME, raw_angle, speed, current, stamp_now);
            end else if (pick < 90) begin
                send_item(MODE_QUERY, 13'($urandom), 16'($urandom), 16'($urandom),
                          stamp_now + 16'($urandom_range(0, 1500)));
            end else if (pick < 95) begin
                send_item(MODE_QUERY, 13'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else begin
                stamp_now = 16'($urandom);
                send_item(MODE_FRAME, 13'($urandom), 16'($urandom), 16'($urandom), stamp_now);
            end
        end
    endtask

    task automatic test_random_phases();
        bit directions[6] = '{DIR_FORWARD, DIR_REVERSE, DIR_REVERSE,
                              DIR_FORWARD, DIR_REVERSE, DIR_FORWARD};
        foreach (directions[p]) begin
            set_direction(directions[p]);
            random_items(100);
            wait_results_drained();
            random_items(105);
        end
    endtask

    always @(posedge i_clk) begin
        ready_count++;
        if (ready_count % 200 == 0) begin
            ready_style = t_ready_style'($urandom_range(0, 3));
        end
        case (ready_style)
            READY_ALWAYS: begin
                m_axis_tready <= 1'b1;
            end
            READY_RANDOM: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            READY_PERIODIC: begin
                m_axis_tready <= ((ready_count % 7) < 4);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(5, 30);
                    end
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_feedback_result got;
        t_feedback_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.angle = m_axis_tdata[M_SPEED_LSB-1:0];
            got.speed = m_axis_tdata[M_SPEED_LSB +: SPEED_W];
            got.current = m_axis_tdata[M_CURRENT_LSB +: CURRENT_W];
            got.stamp = m_axis_tdata[M_STAMP_LSB +: STAMP_W];
            got.sum = m_axis_tdata[M_SUM_LSB +: SUM_W];
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no expectation", got.sum, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
                if (got.speed !== want.speed) report_mismatch("speed", got.speed, want.speed);
                if (got.current !== want.current) begin
                    report_mismatch("current", got.current, want.current);
                end
                if (got.stamp !== want.stamp) report_mismatch("stamp", got.stamp, want.stamp);
                if (got.sum !== want.sum) report_mismatch("angle sum", got.sum, want.sum);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("encoder_feedback_unwrap_estimate_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_forward();
        test_directed_reverse();
        test_random_phases();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d feedback frames and %0d estimate queries, checked %0d results.",
                 frames_sent, queries_sent, results_seen);
        $display("Direction register written %0d times; %0d mismatches found.",
                 direction_writes, error_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("encoder_feedback_unwrap_estimate_test: clean");
        end else begin
            $display("encoder_feedback_unwrap_estimate_test: errors");
        end
        $finish;
    end

endmodule
